// File: src/pcd_pkg.sv
package pcd_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int MAX_NEIGHBOR_K = 16;

    localparam int WIN_DEPTH = 2 * MAX_NEIGHBOR_K + 1;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int PEND_W    = $clog2(MAX_NEIGHBOR_K + 2);
    localparam int POINT_W   = 2 * COORD_WIDTH;

    localparam int K_W       = 5;
    localparam int THR_W     = 16;
    localparam int THR_FRAC  = 15;
    localparam int INDEX_W   = 16;
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_COS_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOR_K    = 1'd1;
    localparam logic [THR_W-1:0] COS_THRESHOLD_RESET = THR_W'(-23170);
    localparam logic [K_W-1:0]   NEIGHBOR_K_RESET    = K_W'(3);

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int MAG_W   = COORD_WIDTH;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int DOT_W   = PROD_W + 1;
    localparam int LEN_W   = PROD_W + 1;
    localparam int DM2_W   = 2 * DOT_W;
    localparam int C2_W    = 2 * THR_W - 1;
    localparam int R1_W    = C2_W + LEN_W;
    localparam int RHS_W   = R1_W + LEN_W;
    localparam int Q_SHIFT = 2 * THR_FRAC;
    localparam int LHS_W   = DM2_W + Q_SHIFT;
    localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_A_W     = R1_W;
    localparam int MUL_B_W     = DOT_W;
    localparam int MUL_STEPS   = (MUL_B_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
    localparam int MUL_B_PAD   = MUL_STEPS * MUL_DIGIT_W;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_PAD;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    typedef enum logic [0:0] {
        READ_CURRENT,
        READ_BACK
    } rd_sel_t;

    typedef enum logic [3:0] {
        OP_P,
        OP_Q,
        OP_AX2,
        OP_AY2,
        OP_BX2,
        OP_BY2,
        OP_DM2,
        OP_C2,
        OP_R1,
        OP_RHS
    } mul_op_t;

    typedef enum logic [1:0] {
        V_HOLD,
        V_CLEAR,
        V_EARLY,
        V_COMPARE
    } verdict_t;

    typedef struct packed {
        logic     accept;
        rd_sel_t  rd_sel;
        logic     load_cur;
        logic     load_back;
        logic     mul_start;
        mul_op_t  mul_op;
        verdict_t verdict;
        logic     emit;
    } pcd_cmd_t;

    typedef struct packed {
        logic need_judge;
        logic trivial;
        logic early_hit;
        logic mul_done;
        logic out_free;
    } pcd_status_t;

endpackage

// File: src/pcd_point_if.sv
interface pcd_point_if
    import pcd_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          is_last_point;

    modport source (
        output valid,
        output point_x,
        output point_y,
        output is_last_point,
        input  ready
    );

    modport sink (
        input  valid,
        input  point_x,
        input  point_y,
        input  is_last_point,
        output ready
    );
endinterface

// File: src/pcd_result_if.sv
interface pcd_result_if
    import pcd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] point_index;
    logic               is_corner;
    logic               is_final_result;

    modport source (
        output valid,
        output point_index,
        output is_corner,
        output is_final_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  point_index,
        input  is_corner,
        input  is_final_result,
        output ready
    );
endinterface

// File: src/polyline_corner_detector.sv
// A point is accepted in the idle state; a point that completes no judgment passes through
// the check state back to idle, and the block is ready again.
// Each judged point then ends at once at the first or last point or on a zero neighbor vector,
// after the dot product when its sign settles the test, and after ten products for the full
// test, on the shared multiplier that takes eight bits of its second operand per cycle.
// A point causes from zero to seventeen words; the result word of point i appears once
// point i+k has arrived, or at the last point. Reset is asynchronous and active low; it clears
// the counters, handshakes and state and sets the two config registers to their reset values.
module polyline_corner_detector
    import pcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pcd_point_if.sink              points,
    pcd_result_if.source           results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    pcd_cmd_t    cmd;
    pcd_status_t status;
    logic        in_ready;

    pcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (points.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pcd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .point_x         (points.point_x),
        .point_y         (points.point_y),
        .is_last_point   (points.is_last_point),
        .cmd             (cmd),
        .status          (status),
        .result_ready    (results.ready),
        .result_valid    (results.valid),
        .point_index     (results.point_index),
        .is_corner       (results.is_corner),
        .is_final_result (results.is_final_result)
    );

    assign points.ready = in_ready;
endmodule

// File: src/pcd_mul.sv
module pcd_mul
    import pcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] product,
    output logic               done
);
    logic [MUL_A_W-1:0]             a_reg;
    logic [MUL_P_W-1:0]             prod_reg;
    logic [MUL_P_W-1:0]             prod_next;
    logic [MUL_A_W+MUL_DIGIT_W-1:0] step_sum;
    logic [MUL_CNT_W-1:0]           cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    always_comb
    begin
        step_sum = {{MUL_DIGIT_W{1'b0}}, prod_reg[MUL_P_W-1:MUL_B_PAD]}
                 + (a_reg * prod_reg[MUL_DIGIT_W-1:0]);
        prod_next = {step_sum, prod_reg[MUL_B_PAD-1:MUL_DIGIT_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{MUL_A_W{1'b0}}, MUL_B_PAD'(b)};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;
endmodule

// File: src/pcd_datapath.sv
module pcd_datapath
    import pcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [COORD_WIDTH-1:0] point_x,
    input  logic [COORD_WIDTH-1:0] point_y,
    input  logic                   is_last_point,
    input  pcd_cmd_t               cmd,
    output pcd_status_t            status,
    input  logic                   result_ready,
    output logic                   result_valid,
    output logic [INDEX_W-1:0]     point_index,
    output logic                   is_corner,
    output logic                   is_final_result
);
    logic [THR_W-1:0] cos_threshold_reg;
    logic [K_W-1:0]   neighbor_k_reg;

    logic [POINT_W-1:0] win_mem [WIN_DEPTH];
    logic [POINT_W-1:0] rd_data_reg;
    logic [WIN_AW-1:0]  rd_addr;

    logic [WIN_AW-1:0]  wr_pos_reg;
    logic [PEND_W-1:0]  pending_reg;
    logic [INDEX_W-1:0] next_to_judge_reg;
    logic               have_first_reg;
    logic               last_reg;
    logic               out_valid_reg;

    logic [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic [COORD_WIDTH-1:0] cur_x_reg, cur_y_reg;
    logic [COORD_WIDTH-1:0] jx_reg, jy_reg;
    logic [DIFF_W-1:0]      ax_reg, ay_reg, bx_reg, by_reg;
    logic [PROD_W-1:0]      p_reg, q_reg;
    logic [DOT_W-1:0]       dm_reg;
    logic                   dneg_reg;
    logic [LEN_W-1:0]       l1_reg, l2_reg;
    logic [DM2_W-1:0]       dm2_reg;
    logic [C2_W-1:0]        c2_reg;
    logic [R1_W-1:0]        r1_reg;
    logic [RHS_W-1:0]       rhs_reg;
    logic                   corner_reg;
    logic [INDEX_W-1:0]     out_index_reg;
    logic                   out_corner_reg;
    logic                   out_final_reg;

    logic [K_W-1:0]         kc;
    logic [PEND_W-1:0]      off;
    logic [WIN_AW-1:0]      back_off;
    logic                   use_first;
    logic                   is_final;
    logic [COORD_WIDTH-1:0] back_x, back_y;
    logic [MAG_W-1:0]       ax_mag, ay_mag, bx_mag, by_mag;
    logic [THR_W-1:0]       thr_mag;
    logic signed [PROD_W+1:0] term_p, term_q, dot_s;
    logic [PROD_W+1:0]      dot_abs;
    logic                   dot_neg;
    logic [DOT_W-1:0]       dot_mag;
    logic                   thr_neg, thr_zero;
    logic [CMP_W-1:0]       lhs_ext, rhs_ext;
    logic [LHS_W-1:0]       lhs;
    logic                   cmp_corner;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_P_W-1:0]     mul_product;
    logic                   mul_done;

    function automatic logic [MAG_W-1:0] diff_mag(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] t;
        t = d[DIFF_W-1] ? (~d + 1'b1) : d;
        return t[MAG_W-1:0];
    endfunction

    function automatic logic [WIN_AW-1:0] ring_addr(input logic [WIN_AW-1:0] wp,
                                                    input logic [WIN_AW-1:0] o);
        logic [WIN_AW:0] s;
        s = {1'b0, wp} + (WIN_AW+1)'(WIN_DEPTH - 1) - {1'b0, o};
        if (s >= (WIN_AW+1)'(WIN_DEPTH))
        begin
            s = s - (WIN_AW+1)'(WIN_DEPTH);
        end
        return s[WIN_AW-1:0];
    endfunction

    function automatic logic [DIFF_W-1:0] sub_coord(input logic [COORD_WIDTH-1:0] u,
                                                    input logic [COORD_WIDTH-1:0] v);
        return {u[COORD_WIDTH-1], u} - {v[COORD_WIDTH-1], v};
    endfunction

    always_comb
    begin
        if (neighbor_k_reg == '0)
        begin
            kc = K_W'(1);
        end
        else if (int'(neighbor_k_reg) > MAX_NEIGHBOR_K)
        begin
            kc = K_W'(MAX_NEIGHBOR_K);
        end
        else
        begin
            kc = neighbor_k_reg;
        end
    end

    assign off       = pending_reg - 1'b1;
    assign back_off  = WIN_AW'(off) + WIN_AW'(kc);
    assign use_first = int'(next_to_judge_reg) < int'(kc);
    assign is_final  = last_reg && (pending_reg == PEND_W'(1));
    assign rd_addr   = (cmd.rd_sel == READ_BACK) ? ring_addr(wr_pos_reg, back_off)
                                                 : ring_addr(wr_pos_reg, WIN_AW'(off));

    assign back_x = use_first ? first_x_reg : rd_data_reg[POINT_W-1:COORD_WIDTH];
    assign back_y = use_first ? first_y_reg : rd_data_reg[COORD_WIDTH-1:0];

    assign ax_mag = diff_mag(ax_reg);
    assign ay_mag = diff_mag(ay_reg);
    assign bx_mag = diff_mag(bx_reg);
    assign by_mag = diff_mag(by_reg);

    assign thr_neg  = cos_threshold_reg[THR_W-1];
    assign thr_zero = (cos_threshold_reg == '0);
    assign thr_mag  = thr_neg ? (~cos_threshold_reg + 1'b1) : cos_threshold_reg;

    always_comb
    begin
        term_p  = $signed({2'b00, p_reg});
        term_q  = $signed({2'b00, q_reg});
        if (ax_reg[DIFF_W-1] ^ bx_reg[DIFF_W-1])
        begin
            term_p = -term_p;
        end
        if (ay_reg[DIFF_W-1] ^ by_reg[DIFF_W-1])
        begin
            term_q = -term_q;
        end
        dot_s   = term_p + term_q;
        dot_neg = dot_s[PROD_W+1];
        dot_abs = dot_neg ? (~dot_s + 1'b1) : dot_s;
        dot_mag = dot_abs[DOT_W-1:0];
    end

    assign lhs        = {dm2_reg, {Q_SHIFT{1'b0}}};
    assign lhs_ext    = CMP_W'(lhs);
    assign rhs_ext    = CMP_W'(rhs_reg);
    assign cmp_corner = dneg_reg ? (lhs_ext > rhs_ext) : (lhs_ext < rhs_ext);

    always_comb
    begin
        case (cmd.mul_op)
            OP_P:
            begin
                mul_a = MUL_A_W'(ax_mag);
                mul_b = MUL_B_W'(bx_mag);
            end
            OP_Q:
            begin
                mul_a = MUL_A_W'(ay_mag);
                mul_b = MUL_B_W'(by_mag);
            end
            OP_AX2:
            begin
                mul_a = MUL_A_W'(ax_mag);
                mul_b = MUL_B_W'(ax_mag);
            end
            OP_AY2:
            begin
                mul_a = MUL_A_W'(ay_mag);
                mul_b = MUL_B_W'(ay_mag);
            end
            OP_BX2:
            begin
                mul_a = MUL_A_W'(bx_mag);
                mul_b = MUL_B_W'(bx_mag);
            end
            OP_BY2:
            begin
                mul_a = MUL_A_W'(by_mag);
                mul_b = MUL_B_W'(by_mag);
            end
            OP_DM2:
            begin
                mul_a = MUL_A_W'(dm_reg);
                mul_b = MUL_B_W'(dm_reg);
            end
            OP_C2:
            begin
                mul_a = MUL_A_W'(thr_mag);
                mul_b = MUL_B_W'(thr_mag);
            end
            OP_R1:
            begin
                mul_a = MUL_A_W'(c2_reg);
                mul_b = MUL_B_W'(l1_reg);
            end
            OP_RHS:
            begin
                mul_a = MUL_A_W'(r1_reg);
                mul_b = MUL_B_W'(l2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pcd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product),
        .done    (mul_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            win_mem[wr_pos_reg] <= {point_x, point_y};
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_threshold_reg <= COS_THRESHOLD_RESET;
            neighbor_k_reg    <= NEIGHBOR_K_RESET;
            wr_pos_reg        <= '0;
            pending_reg       <= '0;
            next_to_judge_reg <= '0;
            have_first_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COS_THRESHOLD: cos_threshold_reg <= cfg_data[THR_W-1:0];
                    CFG_NEIGHBOR_K:    neighbor_k_reg    <= cfg_data[K_W-1:0];
                    default:           ;
                endcase
            end

            if (cmd.accept)
            begin
                wr_pos_reg <= (wr_pos_reg == WIN_AW'(WIN_DEPTH - 1)) ? '0
                                                                      : wr_pos_reg + 1'b1;
                have_first_reg <= 1'b1;
                if (int'(pending_reg) <= MAX_NEIGHBOR_K)
                begin
                    pending_reg <= pending_reg + 1'b1;
                end
            end

            if (cmd.emit)
            begin
                pending_reg <= pending_reg - 1'b1;
                if (is_final)
                begin
                    next_to_judge_reg <= '0;
                    have_first_reg    <= 1'b0;
                end
                else if (next_to_judge_reg != INDEX_MAX)
                begin
                    next_to_judge_reg <= next_to_judge_reg + 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_x_reg <= point_x;
            cur_y_reg <= point_y;
            last_reg  <= is_last_point;
            if (!have_first_reg)
            begin
                first_x_reg <= point_x;
                first_y_reg <= point_y;
            end
        end

        if (cmd.load_cur)
        begin
            jx_reg <= rd_data_reg[POINT_W-1:COORD_WIDTH];
            jy_reg <= rd_data_reg[COORD_WIDTH-1:0];
        end

        if (cmd.load_back)
        begin
            ax_reg <= sub_coord(back_x, jx_reg);
            ay_reg <= sub_coord(back_y, jy_reg);
            bx_reg <= sub_coord(cur_x_reg, jx_reg);
            by_reg <= sub_coord(cur_y_reg, jy_reg);
        end

        if (mul_done)
        begin
            case (cmd.mul_op)
                OP_P:    p_reg   <= mul_product[PROD_W-1:0];
                OP_Q:    q_reg   <= mul_product[PROD_W-1:0];
                OP_AX2:  l1_reg  <= LEN_W'(mul_product[PROD_W-1:0]);
                OP_AY2:  l1_reg  <= l1_reg + LEN_W'(mul_product[PROD_W-1:0]);
                OP_BX2:  l2_reg  <= LEN_W'(mul_product[PROD_W-1:0]);
                OP_BY2:  l2_reg  <= l2_reg + LEN_W'(mul_product[PROD_W-1:0]);
                OP_DM2:  dm2_reg <= mul_product[DM2_W-1:0];
                OP_C2:   c2_reg  <= mul_product[C2_W-1:0];
                OP_R1:   r1_reg  <= mul_product[R1_W-1:0];
                OP_RHS:  rhs_reg <= mul_product[RHS_W-1:0];
                default: ;
            endcase
        end

        case (cmd.verdict)
            V_CLEAR:
            begin
                corner_reg <= 1'b0;
            end
            V_EARLY:
            begin
                dm_reg     <= dot_mag;
                dneg_reg   <= dot_neg;
                corner_reg <= dot_neg;
            end
            V_COMPARE:
            begin
                corner_reg <= cmp_corner;
            end
            default: ;
        endcase

        if (cmd.emit)
        begin
            out_index_reg  <= next_to_judge_reg;
            out_corner_reg <= corner_reg;
            out_final_reg  <= is_final;
        end
    end

    always_comb
    begin
        status.need_judge = last_reg ? (pending_reg != '0)
                                     : (int'(pending_reg) > int'(kc));
        status.trivial    = (pending_reg == PEND_W'(1))
                         || (next_to_judge_reg == '0)
                         || ((ax_reg == '0) && (ay_reg == '0))
                         || ((bx_reg == '0) && (by_reg == '0));
        status.early_hit  = (dot_neg && !thr_neg) || (!dot_neg && (thr_neg || thr_zero));
        status.mul_done   = mul_done;
        status.out_free   = !out_valid_reg || result_ready;
    end

    assign result_valid    = out_valid_reg;
    assign point_index     = out_index_reg;
    assign is_corner       = out_corner_reg;
    assign is_final_result = out_final_reg;
endmodule

// File: src/pcd_ctrl.sv
module pcd_ctrl
    import pcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pcd_status_t status,
    output pcd_cmd_t    cmd
);
    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_CHECK     = 11'b00000000010,
        S_READ_CUR  = 11'b00000000100,
        S_READ_BACK = 11'b00000001000,
        S_LOAD_BACK = 11'b00000010000,
        S_TEST      = 11'b00000100000,
        S_MUL_START = 11'b00001000000,
        S_MUL_WAIT  = 11'b00010000000,
        S_DOT       = 11'b00100000000,
        S_COMPARE   = 11'b01000000000,
        S_EMIT      = 11'b10000000000
    } state_t;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;

    function automatic mul_op_t following_op(input mul_op_t op);
        mul_op_t n;
        case (op)
            OP_P:    n = OP_Q;
            OP_AX2:  n = OP_AY2;
            OP_AY2:  n = OP_BX2;
            OP_BX2:  n = OP_BY2;
            OP_BY2:  n = OP_DM2;
            OP_DM2:  n = OP_C2;
            OP_C2:   n = OP_R1;
            OP_R1:   n = OP_RHS;
            default: n = OP_P;
        endcase
        return n;
    endfunction

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.rd_sel  = READ_CURRENT;
        cmd.mul_op  = op_reg;
        cmd.verdict = V_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.need_judge ? S_READ_CUR : S_IDLE;
            end
            S_READ_CUR:
            begin
                state_next = S_READ_BACK;
            end
            S_READ_BACK:
            begin
                cmd.rd_sel   = READ_BACK;
                cmd.load_cur = 1'b1;
                state_next   = S_LOAD_BACK;
            end
            S_LOAD_BACK:
            begin
                cmd.load_back = 1'b1;
                state_next    = S_TEST;
            end
            S_TEST:
            begin
                if (status.trivial)
                begin
                    cmd.verdict = V_CLEAR;
                    state_next  = S_EMIT;
                end
                else
                begin
                    op_next    = OP_P;
                    state_next = S_MUL_START;
                end
            end
            S_MUL_START:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    if (op_reg == OP_Q)
                    begin
                        state_next = S_DOT;
                    end
                    else if (op_reg == OP_RHS)
                    begin
                        state_next = S_COMPARE;
                    end
                    else
                    begin
                        op_next    = following_op(op_reg);
                        state_next = S_MUL_START;
                    end
                end
            end
            S_DOT:
            begin
                cmd.verdict = V_EARLY;
                if (status.early_hit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    op_next    = OP_AX2;
                    state_next = S_MUL_START;
                end
            end
            S_COMPARE:
            begin
                cmd.verdict = V_COMPARE;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_P;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end
endmodule

// File: bench/corner_verdict_checker.sv
`timescale 1ns / 1ps

module corner_verdict_checker
    import pcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pcd_point_if                   points,
    pcd_result_if                  results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     results_owed
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [INDEX_W-1:0] point_index;
        logic               is_corner;
        logic               is_final_result;
    } corner_verdict_t;

    logic signed [THR_W-1:0]       threshold;
    logic [K_W-1:0]                k_setting;
    logic signed [COORD_WIDTH-1:0] ring_x [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] ring_y [WIN_DEPTH];
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic [INDEX_W-1:0]            seen_count;
    logic [INDEX_W-1:0]            judge_index;
    int unsigned                   unjudged;
    int unsigned                   ring_wr;
    corner_verdict_t               owed_verdicts[$];

    function automatic int unsigned ring_slot(input int unsigned back);
        return (ring_wr + WIN_DEPTH - 1 - (back % WIN_DEPTH)) % WIN_DEPTH;
    endfunction

    // The cosine test is done on squares, so the sign of the dot product and of the
    // threshold are settled first.
    function automatic logic judge_corner(input int unsigned back, input int unsigned k);
        logic signed [63:0] cx, cy, qx, qy, px, py, ax, ay, bx, by, dot, thr;
        logic [127:0]       dot_mag, thr_mag, len1, len2, lhs, rhs;
        int unsigned        slot;
        if (back == 0 || judge_index == 0)
            return 1'b0;
        slot = ring_slot(back);
        cx = 64'(ring_x[slot]);
        cy = 64'(ring_y[slot]);
        slot = ring_slot(0);
        qx = 64'(ring_x[slot]);
        qy = 64'(ring_y[slot]);
        if (judge_index < k)
        begin
            px = 64'(start_x);
            py = 64'(start_y);
        end
        else
        begin
            slot = ring_slot(back + k);
            px = 64'(ring_x[slot]);
            py = 64'(ring_y[slot]);
        end
        ax = px - cx;
        ay = py - cy;
        bx = qx - cx;
        by = qy - cy;
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0))
            return 1'b0;
        dot = ax * bx + ay * by;
        thr = 64'(threshold);
        if (dot < 0 && thr >= 0)
            return 1'b1;
        if (dot >= 0 && thr <= 0)
            return 1'b0;
        dot_mag = 128'((dot < 0) ? -dot : dot);
        thr_mag = 128'((thr < 0) ? -thr : thr);
        len1 = 128'(ax * ax + ay * ay);
        len2 = 128'(bx * bx + by * by);
        lhs = (dot_mag * dot_mag) << (2 * THR_FRAC);
        rhs = thr_mag * thr_mag * len1 * len2;
        return (dot < 0) ? (lhs > rhs) : (lhs < rhs);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        int unsigned     k_eff;
        logic            last_pt;
        corner_verdict_t verdict;
        corner_verdict_t got;
        corner_verdict_t want;
        if (!rst_n)
        begin
            threshold = COS_THRESHOLD_RESET;
            k_setting = NEIGHBOR_K_RESET;
            seen_count = '0;
            judge_index = '0;
            unjudged = 0;
            ring_wr = 0;
            owed_verdicts.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_COS_THRESHOLD)
                    threshold = cfg_data[THR_W-1:0];
                else if (cfg_index == CFG_NEIGHBOR_K)
                    k_setting = cfg_data[K_W-1:0];
            end

            if (points.valid && points.ready)
            begin
                k_eff = 32'(k_setting);
                if (k_eff < 1)
                    k_eff = 1;
                if (k_eff > MAX_NEIGHBOR_K)
                    k_eff = MAX_NEIGHBOR_K;
                last_pt = points.is_last_point;
                ring_x[ring_wr] = points.point_x;
                ring_y[ring_wr] = points.point_y;
                ring_wr = (ring_wr + 1) % WIN_DEPTH;
                if (seen_count == 0)
                begin
                    start_x = points.point_x;
                    start_y = points.point_y;
                end
                if (seen_count != INDEX_MAX)
                    seen_count++;
                if (unjudged <= MAX_NEIGHBOR_K)
                    unjudged++;
                while (last_pt ? (unjudged != 0) : (unjudged > k_eff))
                begin
                    verdict.is_corner = judge_corner(unjudged - 1, k_eff);
                    verdict.point_index = judge_index;
                    verdict.is_final_result = last_pt && (unjudged == 1);
                    owed_verdicts.insert(owed_verdicts.size(), verdict);
                    if (judge_index != INDEX_MAX)
                        judge_index++;
                    unjudged--;
                end
                if (last_pt)
                begin
                    seen_count = '0;
                    judge_index = '0;
                end
            end

            if (results.valid && results.ready)
            begin
                got.point_index = results.point_index;
                got.is_corner = results.is_corner;
                got.is_final_result = results.is_final_result;
                if (owed_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result word: index %0d corner %0b last %0b",
                                 got.point_index, got.is_corner, got.is_final_result);
                end
                else
                begin
                    want = owed_verdicts.pop_front();
                    if (got.point_index != want.point_index
                        || got.is_corner != want.is_corner
                        || got.is_final_result != want.is_final_result)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result word mismatch: expected index %0d corner %0b ",
                                      "last %0b, got index %0d corner %0b last %0b"},
                                     want.point_index, want.is_corner, want.is_final_result,
                                     got.point_index, got.is_corner, got.is_final_result);
                    end
                end
            end
        end
        results_owed = owed_verdicts.size();
    end

endmodule

// File: bench/polyline_corner_detector_tb.sv
`timescale 1ns / 1ps

module polyline_corner_detector_tb;
    import pcd_pkg::*;

    localparam int          LONG_HOLD     = 600;
    localparam int          SETTLE_CYCLES = 50;
    localparam int          PHASE_POINTS  = 22;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     results_owed;
    int unsigned            cycle_count = 0;
    logic                   idling = 1'b1;
    logic                   hold_request = 1'b0;
    logic signed [COORD_WIDTH-1:0] walk_x = '0;
    logic signed [COORD_WIDTH-1:0] walk_y = '0;

    pcd_point_if  point_bus ();
    pcd_result_if verdict_bus ();

    polyline_corner_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (point_bus),
        .results   (verdict_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    corner_verdict_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .points       (point_bus),
        .results      (verdict_bus),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        verdict_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                verdict_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                verdict_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                verdict_bus.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y,
                              input logic last_pt);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            point_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        point_bus.valid <= 1'b1;
        point_bus.point_x <= x;
        point_bus.point_y <= y;
        point_bus.is_last_point <= last_pt;
        do
            @(posedge clk);
        while (!point_bus.ready);
    endtask

    task automatic wait_idle();
        point_bus.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COORD_WIDTH-1:0] extreme_coord();
        case ($urandom_range(0, 3))
            0: return {1'b1, {(COORD_WIDTH - 1){1'b0}}};
            1: return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Mostly a short random walk, so that both sharp and shallow bends turn up.
    task automatic wander();
        case ($urandom_range(0, 15))
            0: ;
            1:
            begin
                walk_x = COORD_WIDTH'($urandom);
                walk_y = COORD_WIDTH'($urandom);
            end
            2:
            begin
                walk_x = extreme_coord();
                walk_y = extreme_coord();
            end
            3, 4:
            begin
                walk_x = walk_x + COORD_WIDTH'($urandom_range(0, 8192) - 4096);
                walk_y = walk_y + COORD_WIDTH'($urandom_range(0, 8192) - 4096);
            end
            default:
            begin
                walk_x = walk_x + COORD_WIDTH'($urandom_range(0, 128) - 64);
                walk_y = walk_y + COORD_WIDTH'($urandom_range(0, 128) - 64);
            end
        endcase
    endtask

    task automatic run_phase(input int budget, input logic may_leave_open);
        int                    plen;
        logic                  open_end;
        logic [CFG_DATA_W-1:0] thr_word;
        logic [CFG_DATA_W-1:0] k_word;
        case ($urandom_range(0, 5))
            0: thr_word = 16'h8000;
            1: thr_word = 16'h7fff;
            2: thr_word = '0;
            default: thr_word = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: k_word = '0;
            1: k_word = CFG_DATA_W'(MAX_NEIGHBOR_K);
            2: k_word = CFG_DATA_W'($urandom_range(MAX_NEIGHBOR_K + 1, 31));
            default: k_word = CFG_DATA_W'($urandom_range(1, MAX_NEIGHBOR_K));
        endcase
        write_reg(CFG_COS_THRESHOLD, thr_word);
        write_reg(CFG_NEIGHBOR_K, k_word);
        while (budget > 0)
        begin
            case ($urandom_range(0, 9))
                0: plen = $urandom_range(1, 2);
                1: plen = $urandom_range(25, 40);
                default: plen = $urandom_range(3, 20);
            endcase
            open_end = 1'b0;
            if (plen >= budget)
            begin
                plen = budget;
                open_end = may_leave_open && ($urandom_range(0, 2) == 0);
            end
            for (int j = 0; j < plen; j++)
            begin
                wander();
                send_point(walk_x, walk_y, (j == plen - 1) && !open_end);
            end
            budget -= plen;
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        point_bus.valid <= 1'b0;
        point_bus.point_x <= '0;
        point_bus.point_y <= '0;
        point_bus.is_last_point <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_COS_THRESHOLD, '0);
        write_reg(CFG_NEIGHBOR_K, CFG_DATA_W'(1));
        send_point(16'sh8000, 16'sh7fff, 1'b1);
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd160, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd16, 1'b0);
        send_point(16'sd0, 16'sd16, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b1);
        wait_idle();

        write_reg(CFG_COS_THRESHOLD, 16'h7fff);
        write_reg(CFG_NEIGHBOR_K, CFG_DATA_W'(31));
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sd100, -16'sd100, 1'b1);
        wait_idle();

        write_reg(CFG_COS_THRESHOLD, 16'h8000);
        write_reg(CFG_NEIGHBOR_K, CFG_DATA_W'(1));
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd100, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        wait_idle();

        write_reg(CFG_COS_THRESHOLD, COS_THRESHOLD_RESET);
        write_reg(CFG_NEIGHBOR_K, CFG_DATA_W'(3));
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd10, 16'sd0, 1'b0);
        send_point(16'sd20, 16'sd0, 1'b0);
        send_point(16'sd20, 16'sd10, 1'b0);
        send_point(16'sd10, 16'sd10, 1'b0);
        wait_idle();
        write_reg(CFG_NEIGHBOR_K, CFG_DATA_W'(1));
        send_point(16'sd0, 16'sd10, 1'b0);
        send_point(16'sd0, 16'sd20, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
            run_phase(PHASE_POINTS, 1'b1);

        // The receiver holds off while points keep coming, so the block backs up.
        idling = 1'b0;
        write_reg(CFG_COS_THRESHOLD, CFG_DATA_W'($urandom));
        write_reg(CFG_NEIGHBOR_K, CFG_DATA_W'(MAX_NEIGHBOR_K));
        hold_request = 1'b1;
        for (int j = 0; j < 50; j++)
        begin
            wander();
            send_point(walk_x, walk_y, j == 49);
        end
        wait_idle();

        run_phase(PHASE_POINTS, 1'b0);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
